// ===== rtl/ltp_pkg.sv =====
// ----------------------------------------------------------------------------
// ltp_pkg: shared types and constants of the lottery task pool
// Operation and status codes, default depths, controller command struct.
// ----------------------------------------------------------------------------
package ltp_pkg;

  localparam int unsigned PoolDepthDef  = 16;
  localparam int unsigned StackDepthDef = 8;
  localparam logic [3:0]  StackLimitRst = 4'd4;

  typedef enum logic [2:0] {
    OP_ADD     = 3'd0,
    OP_PICK    = 3'd1,
    OP_PROMOTE = 3'd2,
    OP_FINISH  = 3'd3,
    OP_PEEK    = 3'd4
  } op_e;

  typedef enum logic [2:0] {
    ST_OK      = 3'd0,
    ST_MISS    = 3'd1,
    ST_DUP     = 3'd2,
    ST_INVALID = 3'd3,
    ST_FULL    = 3'd4
  } status_e;

  typedef enum logic [3:0] {
    S_IDLE,
    S_SCAN,      // walk pool: dup check, total, insert position, id search
    S_POINT,     // compute pick point
    S_PICK,      // second walk for pick
    S_SHIFT_IN,  // open gap, shift entries up one per cycle
    S_SHIFT_OUT, // close gap, shift entries down one per cycle
    S_STACK,     // stack push / evict
    S_FINISH,    // decide return path of popped task
    S_DONE
  } state_e;

  // controller -> datapath
  typedef struct packed {
    logic load;      // capture input item, clear walk
    logic scan_step; // advance the walk index
    logic point;     // compute pick point
    logic pick_rst;  // restart walk for pick
    logic ins_step;  // one upward shift step / final write
    logic del_step;  // one downward shift step
    logic push;      // stack push
    logic pop;       // stack pop and run update
    logic finish;    // latch finish result, load insert state
  } cmd_t;

  // datapath -> controller
  typedef struct packed {
    logic scan_end;
    logic pick_hit;
    logic ins_end;
    logic del_end;
    logic pool_full;
    logic stack_empty;
    logic found;
    logic total_zero;
    logic dup;
    logic fin_discard;
  } sts_t;

endpackage

// ===== rtl/ltp_ctrl.sv =====
// ----------------------------------------------------------------------------
// ltp_ctrl: command sequencer
// Steps the datapath through walk, shift and stack phases for one item.
// ----------------------------------------------------------------------------
module ltp_ctrl import ltp_pkg::*; (
  input  logic       clk_i,
  input  logic       rst_ni,
  input  logic       in_valid,
  output logic       in_stall,
  input  logic [2:0] op_i,
  input  logic [15:0] id_i,
  input  logic       score_neg_i,
  input  sts_t       sts_i,
  output cmd_t       cmd_o,
  output logic       res_set_o,
  output status_e    res_st_o,
  output logic       res_zero_o,
  input  logic       res_busy_i
);

  state_e   state_q, state_d;
  logic [2:0] op_q;
  logic     zero_id_q, neg_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q   <= S_IDLE;
      op_q      <= '0;
      zero_id_q <= 1'b0;
      neg_q     <= 1'b0;
    end else begin
      state_q <= state_d;
      if (in_valid && !in_stall) begin
        op_q      <= op_i;
        zero_id_q <= (id_i == '0);
        neg_q     <= score_neg_i;
      end
    end
  end

  always_comb begin
    state_d    = state_q;
    cmd_o      = '0;
    res_set_o  = 1'b0;
    res_st_o   = ST_OK;
    res_zero_o = 1'b0;
    in_stall   = 1'b1;
    unique case (state_q)
      S_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd_o.load = 1'b1;
          state_d    = S_SCAN;
        end
      end
      S_SCAN: begin
        if (!sts_i.scan_end) begin
          cmd_o.scan_step = 1'b1;
        end else begin
          unique case (op_q)
            OP_ADD: begin
              if (zero_id_q) begin
                res_st_o = ST_INVALID; res_set_o = 1'b1; state_d = S_DONE;
              end else if (sts_i.dup) begin
                res_st_o = ST_DUP; res_set_o = 1'b1; state_d = S_DONE;
              end else if (neg_q) begin
                res_st_o = ST_INVALID; res_set_o = 1'b1; state_d = S_DONE;
              end else if (sts_i.pool_full) begin
                res_st_o = ST_FULL; res_set_o = 1'b1; state_d = S_DONE;
              end else begin
                state_d = S_SHIFT_IN;
              end
            end
            OP_PICK: begin
              if (sts_i.total_zero) begin
                res_st_o = ST_MISS; res_zero_o = 1'b1; res_set_o = 1'b1;
                state_d  = S_DONE;
              end else begin
                cmd_o.point = 1'b1;
                state_d     = S_POINT;
              end
            end
            OP_PROMOTE: begin
              if (zero_id_q || !sts_i.found) begin
                res_st_o = ST_MISS; res_zero_o = 1'b1; res_set_o = 1'b1;
                state_d  = S_DONE;
              end else begin
                state_d = S_SHIFT_OUT;
              end
            end
            OP_FINISH: begin
              if (sts_i.stack_empty) begin
                res_st_o = ST_MISS; res_zero_o = 1'b1; res_set_o = 1'b1;
                state_d  = S_DONE;
              end else begin
                cmd_o.pop = 1'b1;
                state_d   = S_FINISH;
              end
            end
            OP_PEEK: begin
              res_set_o = 1'b1;
              if (sts_i.stack_empty) begin
                res_st_o = ST_MISS; res_zero_o = 1'b1;
              end
              state_d = S_DONE;
            end
            default: begin
              res_st_o = ST_INVALID; res_zero_o = 1'b1; res_set_o = 1'b1;
              state_d  = S_DONE;
            end
          endcase
        end
      end
      S_POINT: begin
        cmd_o.pick_rst = 1'b1;
        state_d        = S_PICK;
      end
      S_PICK: begin
        if (sts_i.pick_hit) begin
          res_set_o = 1'b1;
          state_d   = S_DONE;
        end else begin
          cmd_o.scan_step = 1'b1;
        end
      end
      S_SHIFT_IN: begin
        cmd_o.ins_step = 1'b1;
        if (sts_i.ins_end) begin
          res_set_o = 1'b1;
          state_d   = S_DONE;
        end
      end
      S_SHIFT_OUT: begin
        cmd_o.del_step = 1'b1;
        if (sts_i.del_end) state_d = S_STACK;
      end
      S_STACK: begin
        cmd_o.push = 1'b1;
        res_set_o  = 1'b1;
        state_d    = S_DONE;
      end
      S_FINISH: begin
        cmd_o.finish = 1'b1;
        if (sts_i.fin_discard) begin
          res_set_o = 1'b1;
          state_d   = S_DONE;
        end else if (sts_i.pool_full) begin
          res_st_o  = ST_FULL;
          res_set_o = 1'b1;
          state_d   = S_DONE;
        end else begin
          state_d = S_SHIFT_IN;
        end
      end
      S_DONE: begin
        if (!res_busy_i) state_d = S_IDLE;
      end
      default: state_d = S_IDLE;
    endcase
  end

endmodule

// ===== rtl/ltp_dp.sv =====
// ----------------------------------------------------------------------------
// ltp_dp: pool and stack storage with walk, shift and roulette arithmetic
// Pool entries are shifted one per cycle on insert and removal.
// ----------------------------------------------------------------------------
module ltp_dp import ltp_pkg::*; #(
  parameter int unsigned POOL_DEPTH  = PoolDepthDef,
  parameter int unsigned STACK_DEPTH = StackDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  cmd_t        cmd_i,
  input  logic [3:0]  stack_limit_i,
  input  logic [2:0]  op_i,
  input  logic [15:0] id_i,
  input  logic signed [15:0] score_i,
  input  logic signed [8:0]  runs_i,
  input  logic [15:0] frac_i,
  output sts_t        sts_o,
  output logic [15:0] out_id_o,
  output logic signed [15:0] out_score_o,
  output logic signed [8:0]  out_runs_o,
  output logic        out_drop_o
);

  localparam int unsigned PW = $clog2(POOL_DEPTH + 1);
  localparam int unsigned PI = (POOL_DEPTH > 1) ? $clog2(POOL_DEPTH) : 1;
  localparam int unsigned SW = $clog2(STACK_DEPTH + 1);
  localparam int unsigned SI = (STACK_DEPTH > 1) ? $clog2(STACK_DEPTH) : 1;
  localparam int unsigned TW = 15 + PW;  // sum of positive Q8.8 scores

  logic [15:0]        p_id_q    [POOL_DEPTH];
  logic signed [15:0] p_score_q [POOL_DEPTH];
  logic signed [8:0]  p_runs_q  [POOL_DEPTH];
  logic [15:0]        s_id_q    [STACK_DEPTH];
  logic signed [15:0] s_score_q [STACK_DEPTH];
  logic signed [8:0]  s_runs_q  [STACK_DEPTH];
  logic [PW-1:0] p_cnt_q;
  logic [SW-1:0] s_cnt_q;

  logic [PW-1:0] idx_q;      // walk index / shift pointer
  logic [PW-1:0] pos_q;      // insert position or found position
  logic          pos_set_q;
  logic          dup_q;
  logic [TW-1:0] total_q, run_q, point_q;
  logic [15:0]   k_id_q;     // item being inserted
  logic signed [15:0] k_score_q;
  logic signed [8:0]  k_runs_q;
  logic [15:0]   r_id_q;
  logic signed [15:0] r_score_q;
  logic signed [8:0]  r_runs_q;
  logic          r_drop_q;
  logic          hit_q;

  logic [PI-1:0] ix;
  logic [15:0]        cur_id;
  logic signed [15:0] cur_score;
  logic [TW+15:0]     prod;
  logic [SI-1:0]      top;
  logic [SW-1:0]      lim;
  logic signed [8:0]  pop_runs;
  logic [PW-1:0]      fin_pos;

  assign ix        = idx_q[PI-1:0];
  assign cur_id    = p_id_q[ix];
  assign cur_score = p_score_q[ix];
  assign prod      = total_q * {{TW{1'b0}}, frac_i};
  assign top       = SI'(s_cnt_q - 1'b1);
  assign pop_runs  = (s_runs_q[top] > 0) ? s_runs_q[top] - 9'sd1 : s_runs_q[top];

  always_comb begin
    if (stack_limit_i == 4'd0) lim = SW'(1);
    else if (32'(stack_limit_i) > STACK_DEPTH) lim = SW'(STACK_DEPTH);
    else lim = SW'(stack_limit_i);
  end

  // insert slot of a returning task: first entry with a smaller score
  always_comb begin
    fin_pos = p_cnt_q;
    for (int i = POOL_DEPTH - 1; i >= 0; i--) begin
      if (32'(i) < 32'(p_cnt_q) && p_score_q[i] < k_score_q) fin_pos = PW'(i);
    end
  end

  always_comb begin
    sts_o             = '0;
    sts_o.scan_end    = (idx_q >= p_cnt_q);
    sts_o.pick_hit    = hit_q;
    sts_o.ins_end     = (idx_q == pos_q);
    sts_o.del_end     = (32'(idx_q) + 1 >= 32'(p_cnt_q));
    sts_o.pool_full   = (32'(p_cnt_q) >= POOL_DEPTH);
    sts_o.stack_empty = (s_cnt_q == '0);
    sts_o.found       = pos_set_q;
    sts_o.total_zero  = (total_q == '0);
    sts_o.dup         = dup_q;
    sts_o.fin_discard = r_drop_q;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      p_cnt_q <= '0;
      s_cnt_q <= '0;
    end else begin
      if (cmd_i.ins_step && idx_q == pos_q) p_cnt_q <= p_cnt_q + 1'b1;
      if (cmd_i.del_step && sts_o.del_end) p_cnt_q <= p_cnt_q - 1'b1;
      if (cmd_i.push) begin
        if (s_cnt_q >= lim) s_cnt_q <= s_cnt_q;
        else s_cnt_q <= s_cnt_q + 1'b1;
      end
      if (cmd_i.pop) s_cnt_q <= s_cnt_q - 1'b1;
    end
  end

  always_ff @(posedge clk_i) begin
    if (cmd_i.load) begin
      idx_q     <= '0;
      pos_set_q <= 1'b0;
      dup_q     <= 1'b0;
      total_q   <= '0;
      run_q     <= '0;
      hit_q     <= 1'b0;
      k_id_q    <= id_i;
      k_score_q <= score_i;
      k_runs_q  <= runs_i;
      r_drop_q  <= 1'b0;
      pos_q     <= p_cnt_q;
      if (op_i == OP_PEEK && s_cnt_q != '0) begin
        r_id_q    <= s_id_q[SI'(s_cnt_q - 1'b1)];
        r_score_q <= s_score_q[SI'(s_cnt_q - 1'b1)];
        r_runs_q  <= s_runs_q[SI'(s_cnt_q - 1'b1)];
      end else begin
        r_id_q    <= id_i;
        r_score_q <= score_i;
        r_runs_q  <= runs_i;
      end
    end
    if (cmd_i.scan_step && !cmd_i.pick_rst) begin
      idx_q <= idx_q + 1'b1;
      if (cur_id == k_id_q) dup_q <= 1'b1;
      if (cur_score > 0) begin
        total_q <= total_q + TW'(unsigned'(cur_score));
        run_q   <= run_q + TW'(unsigned'(cur_score));
        // a pick hit replaces the result fields here; a promote match does so below
        if (op_i == OP_PICK && !hit_q &&
            run_q + TW'(unsigned'(cur_score)) >= point_q) begin
          hit_q     <= 1'b1;
          r_id_q    <= cur_id;
          r_score_q <= cur_score;
          r_runs_q  <= p_runs_q[ix];
        end
      end
      // insert position: first entry with smaller score
      if (!pos_set_q && cur_score < k_score_q && op_i == OP_ADD) begin
        pos_set_q <= 1'b1;
        pos_q     <= idx_q;
      end
      if (!pos_set_q && cur_id == k_id_q && op_i == OP_PROMOTE) begin
        pos_set_q <= 1'b1;
        pos_q     <= idx_q;
        r_id_q    <= cur_id;
        r_score_q <= cur_score;
        r_runs_q  <= p_runs_q[ix];
      end
    end
    if (cmd_i.point) begin
      point_q <= TW'(prod >> 16) + 1'b1;
      run_q   <= '0;
    end
    if (cmd_i.pick_rst) begin
      idx_q <= '0;
      hit_q <= 1'b0;
    end
    // stage for SCAN->SHIFT_IN (add): shift pointer starts at count
    if (cmd_i.scan_step == 1'b0 && op_i == OP_ADD && sts_o.scan_end && !cmd_i.ins_step
        && !cmd_i.load && !cmd_i.point) begin
      idx_q <= p_cnt_q;
    end
    if (cmd_i.ins_step) begin
      if (idx_q == pos_q) begin
        p_id_q[ix]    <= k_id_q;
        p_score_q[ix] <= k_score_q;
        p_runs_q[ix]  <= k_runs_q;
      end else begin
        p_id_q[ix]    <= p_id_q[PI'(idx_q - 1'b1)];
        p_score_q[ix] <= p_score_q[PI'(idx_q - 1'b1)];
        p_runs_q[ix]  <= p_runs_q[PI'(idx_q - 1'b1)];
        idx_q         <= idx_q - 1'b1;
      end
    end
    if (cmd_i.scan_step == 1'b0 && op_i == OP_PROMOTE && sts_o.scan_end && !cmd_i.del_step
        && !cmd_i.load && !cmd_i.push) begin
      idx_q <= pos_q;
    end
    if (cmd_i.del_step) begin
      if (!sts_o.del_end) begin
        p_id_q[ix]    <= p_id_q[PI'(idx_q + 1'b1)];
        p_score_q[ix] <= p_score_q[PI'(idx_q + 1'b1)];
        p_runs_q[ix]  <= p_runs_q[PI'(idx_q + 1'b1)];
        idx_q         <= idx_q + 1'b1;
      end
    end
    if (cmd_i.push) begin
      if (s_cnt_q >= lim) begin
        for (int i = 0; i < STACK_DEPTH; i++) begin
          if (i + 1 < STACK_DEPTH && SW'(i + 1) < s_cnt_q) begin
            s_id_q[i]    <= s_id_q[i+1];
            s_score_q[i] <= s_score_q[i+1];
            s_runs_q[i]  <= s_runs_q[i+1];
          end
        end
        s_id_q[SI'(s_cnt_q - 1'b1)]    <= r_id_q;
        s_score_q[SI'(s_cnt_q - 1'b1)] <= r_score_q;
        s_runs_q[SI'(s_cnt_q - 1'b1)]  <= r_runs_q;
        r_drop_q <= 1'b1;
      end else begin
        s_id_q[SI'(s_cnt_q)]    <= r_id_q;
        s_score_q[SI'(s_cnt_q)] <= r_score_q;
        s_runs_q[SI'(s_cnt_q)]  <= r_runs_q;
      end
    end
    if (cmd_i.pop) begin
      r_id_q    <= s_id_q[top];
      r_score_q <= s_score_q[top];
      r_runs_q  <= pop_runs;
      k_id_q    <= s_id_q[top];
      k_score_q <= s_score_q[top];
      k_runs_q  <= pop_runs;
      r_drop_q  <= (pop_runs == 9'sd0);
      pos_q     <= p_cnt_q;
      pos_set_q <= 1'b0;
      idx_q     <= '0;
    end
    if (cmd_i.finish) begin
      if (!r_drop_q && sts_o.pool_full) r_drop_q <= 1'b1;
      idx_q <= p_cnt_q;
      pos_q <= fin_pos;
    end
  end

  assign out_id_o    = r_id_q;
  assign out_score_o = r_score_q;
  assign out_runs_o  = r_runs_q;
  assign out_drop_o  = r_drop_q;

endmodule

// ===== rtl/lottery_task_pool_with_work_stack.sv =====
// ----------------------------------------------------------------------------
// lottery_task_pool_with_work_stack: sorted task pool with lottery pick
// Roulette-wheel selection over a descending-score pool, plus a work stack.
// ----------------------------------------------------------------------------
//  channel  | handshake               | payload
//  in       | in_valid / in_stall     | operation, routine_id, entry_score,
//           |                         | run_limit, random_fraction
//  out      | out_valid / out_stall   | status, result_id, result_score,
//           |                         | result_runs, dropped
//  cfg      | cfg_we_i                | cfg_data_i (stack_limit)
//
//  One item at a time; the pool is walked once per item, twice for a pick,
//  and add, promote or a returning finish also shift entries past the slot.
//  The result sits in an output register; in_stall stays high until that
//  transfer completes. Reset empties pool and stack and sets stack_limit
//  to 4.
module lottery_task_pool_with_work_stack import ltp_pkg::*; #(
  parameter int unsigned POOL_DEPTH  = PoolDepthDef,
  parameter int unsigned STACK_DEPTH = StackDepthDef
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        cfg_we_i,
  input  logic [3:0]  cfg_data_i,
  input  logic        in_valid,
  output logic        in_stall,
  input  logic [2:0]  operation_i,
  input  logic [15:0] routine_id_i,
  input  logic signed [15:0] entry_score_i,
  input  logic signed [8:0]  run_limit_i,
  input  logic [15:0] random_fraction_i,
  output logic        out_valid,
  input  logic        out_stall,
  output logic [2:0]  status_o,
  output logic [15:0] result_id_o,
  output logic signed [15:0] result_score_o,
  output logic signed [8:0]  result_runs_o,
  output logic        dropped_o
);

  logic [3:0] limit_q;
  cmd_t       cmd;
  sts_t       sts;
  logic       res_set, res_zero;
  status_e    res_st;
  logic [2:0] op_q;
  logic [15:0] id_q, frac_q;
  logic signed [15:0] score_q;
  logic signed [8:0]  runs_q;
  logic [15:0] dp_id;
  logic signed [15:0] dp_score;
  logic signed [8:0]  dp_runs;
  logic       dp_drop;
  logic       out_valid_q;
  status_e    st_q;
  logic       zero_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) limit_q <= StackLimitRst;
    else if (cfg_we_i) limit_q <= cfg_data_i;
  end

  // capture the item so the datapath sees a stable operation
  always_ff @(posedge clk_i) begin
    if (in_valid && !in_stall) begin
      op_q    <= operation_i;
      id_q    <= routine_id_i;
      score_q <= entry_score_i;
      runs_q  <= run_limit_i;
      frac_q  <= random_fraction_i;
    end
  end

  ltp_ctrl u_ctrl (
    .clk_i, .rst_ni, .in_valid, .in_stall,
    .op_i(operation_i), .id_i(routine_id_i), .score_neg_i(entry_score_i[15]),
    .sts_i(sts), .cmd_o(cmd), .res_set_o(res_set), .res_st_o(res_st),
    .res_zero_o(res_zero), .res_busy_i(out_valid_q)
  );

  ltp_dp #(.POOL_DEPTH(POOL_DEPTH), .STACK_DEPTH(STACK_DEPTH)) u_dp (
    .clk_i, .rst_ni, .cmd_i(cmd), .stack_limit_i(limit_q),
    .op_i(cmd.load ? operation_i : op_q),
    .id_i(cmd.load ? routine_id_i : id_q),
    .score_i(cmd.load ? entry_score_i : score_q),
    .runs_i(cmd.load ? run_limit_i : runs_q),
    .frac_i(frac_q), .sts_o(sts),
    .out_id_o(dp_id), .out_score_o(dp_score), .out_runs_o(dp_runs),
    .out_drop_o(dp_drop)
  );

  // result register; datapath result fields are final once out_valid rises
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q <= 1'b0;
    end else if (res_set) begin
      out_valid_q <= 1'b1;
    end else if (out_valid_q && !out_stall) begin
      out_valid_q <= 1'b0;
    end
  end

  always_ff @(posedge clk_i) begin
    if (res_set) begin
      st_q   <= res_st;
      zero_q <= res_zero;
    end
  end

  assign out_valid      = out_valid_q;
  assign status_o       = st_q;
  assign result_id_o    = zero_q ? '0 : dp_id;
  assign result_score_o = zero_q ? '0 : dp_score;
  assign result_runs_o  = zero_q ? '0 : dp_runs;
  assign dropped_o      = zero_q ? 1'b0 : dp_drop;

`ifndef NO_ASSERTIONS
  a_no_accept_busy: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_q |-> in_stall) else $error("accept while result pending");
  a_set_idle_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    res_set |-> !out_valid_q) else $error("result overwritten");
`endif

endmodule
